FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// Condition never holds.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed");

`endif

FILE: hdl/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg
// Types and constants of the button debouncer with long press detection.
// ----------------------------------------------------------------------------
`default_nettype none

package bdlp_pkg;

	localparam int CNT_W     = 16;
	localparam int CFG_IDX_W = 2;

	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [1:0]           act_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// action codes
	localparam act_t ACT_NONE  = 2'd0;
	localparam act_t ACT_PRESS = 2'd1;
	localparam act_t ACT_LONG  = 2'd2;

	// register indexes
	localparam cfg_idx_t REG_PRESS_THRESHOLD      = 2'd0;
	localparam cfg_idx_t REG_LONG_PRESS_THRESHOLD = 2'd1;
	localparam cfg_idx_t REG_DEAD_TIME            = 2'd2;

	// register reset values
	localparam cnt_t RST_PRESS_THRESHOLD      = 16'd20;
	localparam cnt_t RST_LONG_PRESS_THRESHOLD = 16'd0;
	localparam cnt_t RST_DEAD_TIME            = 16'd10;

	localparam cnt_t CNT_MAX = 16'hffff;

	typedef struct packed {
		cnt_t press_threshold;
		cnt_t long_press_threshold;
		cnt_t dead_time;
	} cfg_t;

endpackage

`default_nettype wire

FILE: hdl/bdlp_ifs.sv
// ----------------------------------------------------------------------------
// bdlp channel interfaces
// Valid/ready channels for button samples, actions and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface bdlp_in_if;
	logic valid;
	logic ready;
	logic pressed;

	modport source (output valid, output pressed, input ready);
	modport sink   (input valid, input pressed, output ready);
endinterface

interface bdlp_out_if import bdlp_pkg::*; ();
	logic valid;
	logic ready;
	act_t action;
	act_t last_action;

	modport source (output valid, output action, output last_action, input ready);
	modport sink   (input valid, input action, input last_action, output ready);
endinterface

interface bdlp_cfg_if import bdlp_pkg::*; ();
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	cnt_t     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/button_debounce_long_press_core.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press_core
// Button debouncer with short and long press detection, one sample per
// transaction, one action result per sample.
// ----------------------------------------------------------------------------
//
//  channel  role   payload                      notes
//  -------  -----  ---------------------------  ------------------------------
//  btn      sink   pressed                      one sampled button level
//  evt      source action, last_action          0 none, 1 press, 2 long press
//  cfg      sink   index, data                  0 press thr, 1 long thr, 2 dead
//
//  One sample per cycle sustained while evt keeps up. A sample sits in the input
//  register, then the update logic writes the state and the result register,
//  and the result register offers the result on evt.
//  The input register refills while a result waits; only a stalled result
//  register that is full holds the update, and btn.ready then drops.
//  Reset clears the debounce state and loads register defaults; cfg is
//  always ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module button_debounce_long_press_core import bdlp_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bdlp_in_if.sink    btn,
	bdlp_out_if.source evt,
	bdlp_cfg_if.sink   cfg
);

	cfg_t regs;

	// input stage
	logic valid_s1;
	logic pressed_s1;

	// result stage
	logic valid_s2;
	act_t action_s2;
	act_t last_action_s2;

	act_t step_action;
	act_t step_last_action;

	logic advance;   // sample in s1 is processed into s2 this cycle
	logic s2_free;

	bdlp_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	bdlp_step u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (regs),
		.advance     (advance),
		.pressed     (pressed_s1),
		.action      (step_action),
		.last_action (step_last_action)
	);

	assign s2_free   = !valid_s2 || evt.ready;
	assign advance   = valid_s1 && s2_free;
	assign btn.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (btn.ready) begin
			valid_s1 <= btn.valid;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (btn.ready && btn.valid)
			pressed_s1 <= btn.pressed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_s2      <= step_action;
			last_action_s2 <= step_last_action;
		end
	end

	assign evt.valid       = valid_s2;
	assign evt.action      = action_s2;
	assign evt.last_action = last_action_s2;

	// any fired action is also the newest last action
	`ASSERT_IMPLIES(a_last_tracks_fire, clk, arst_n,
		valid_s2 && (action_s2 != ACT_NONE), last_action_s2 == action_s2)
	`ASSERT_IMPLIES(a_stall_only_when_full, clk, arst_n, !btn.ready, valid_s1 && valid_s2)
	`ASSERT_NEXT(a_advance_fills_s2, clk, arst_n, advance, valid_s2)

endmodule

`default_nettype wire

FILE: hdl/bdlp_cfg_regs.sv
// ----------------------------------------------------------------------------
// bdlp_cfg_regs
// Threshold and dead time registers, written through the config channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bdlp_cfg_regs import bdlp_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	bdlp_cfg_if.sink    cfg,
	output cfg_t        regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.press_threshold      <= RST_PRESS_THRESHOLD;
			regs_q.long_press_threshold <= RST_LONG_PRESS_THRESHOLD;
			regs_q.dead_time            <= RST_DEAD_TIME;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_PRESS_THRESHOLD:      regs_q.press_threshold      <= cfg.data;
				REG_LONG_PRESS_THRESHOLD: regs_q.long_press_threshold <= cfg.data;
				REG_DEAD_TIME:            regs_q.dead_time            <= cfg.data;
				default: ; // unmapped index, write dropped
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hdl/bdlp_step.sv
// ----------------------------------------------------------------------------
// bdlp_step
// Debounce state and the per-sample update: counter, fired flag, armed action, last action.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bdlp_step import bdlp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic advance,
	input  wire logic pressed,
	output act_t      action,
	output act_t      last_action
);

	cnt_t level_count_q;
	logic has_fired_q;
	act_t armed_q;
	act_t prev_q;

	cnt_t cnt_step, cnt_clamp, cnt_nxt;
	logic fired_step, fired_nxt;
	act_t armed_mid, armed_nxt, prev_nxt;
	logic fire;

	always_comb begin
		// integrate the level, saturating both ways
		cnt_step   = level_count_q;
		fired_step = has_fired_q;
		if (pressed) begin
			if (level_count_q != CNT_MAX)
				cnt_step = level_count_q + 16'd1;
		end else if (level_count_q != '0) begin
			cnt_step = level_count_q - 16'd1;
			if (cnt_step == '0)
				fired_step = 1'b0;
		end

		// ceiling while fired
		cnt_clamp = (fired_step && (cnt_step > cfg.dead_time)) ? cfg.dead_time : cnt_step;

		armed_mid = armed_q;
		fire      = 1'b0;
		if (!fired_step) begin
			if ((cfg.long_press_threshold != '0) &&
			    (cnt_clamp >= cfg.long_press_threshold)) begin
				armed_mid = ACT_LONG;
				fire      = 1'b1;
			end else if (cnt_clamp >= cfg.press_threshold) begin
				armed_mid = ACT_PRESS;
				fire      = (cfg.long_press_threshold == '0);
			end
			if ((armed_mid != ACT_NONE) && !pressed)
				fire = 1'b1;
		end

		cnt_nxt   = cnt_clamp;
		fired_nxt = fired_step;
		armed_nxt = armed_mid;
		prev_nxt  = prev_q;
		action    = ACT_NONE;
		if (fire) begin
			cnt_nxt   = cfg.dead_time;
			fired_nxt = 1'b1;
			armed_nxt = ACT_NONE;
			prev_nxt  = armed_mid;
			action    = armed_mid;
		end
		last_action = prev_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_count_q <= '0;
			has_fired_q   <= 1'b0;
			armed_q       <= ACT_NONE;
			prev_q        <= ACT_NONE;
		end else if (advance) begin
			level_count_q <= cnt_nxt;
			has_fired_q   <= fired_nxt;
			armed_q       <= armed_nxt;
			prev_q        <= prev_nxt;
		end
	end

	// a long press fires the moment it arms, so it is never left pending
	`ASSERT_NEVER(a_no_armed_long, clk, arst_n, armed_q == ACT_LONG)
	`ASSERT_IMPLIES(a_fired_disarmed, clk, arst_n, has_fired_q, armed_q == ACT_NONE)
	`ASSERT_NEXT(a_fire_reload, clk, arst_n, advance && fire,
		level_count_q == $past(cfg.dead_time))

endmodule

`default_nettype wire

FILE: sim/button_debounce_long_press_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// button_debounce_long_press_core_tb
// Self-checking bench for the button debouncer. Button samples go in over the
// btn channel, and a model of the counter, the fired flag and the armed action
// predicts each action result, which is then compared with evt. It runs short
// directed sequences, including a hold with the counter reloaded at its top,
// and then random press/release bursts under several register settings and
// idle/stall patterns.
// ----------------------------------------------------------------------------

module button_debounce_long_press_core_tb;

	import bdlp_pkg::*;

	// index with no register behind it, writes are dropped
	localparam cfg_idx_t REG_UNUSED = 2'd3;

	localparam int CYCLE_LIMIT  = 60000;
	localparam int SETTLE_TICKS = 8;
	localparam int PHASE_ITEMS  = 200;
	localparam int RAND_PHASES  = 8;

	typedef struct packed {
		act_t action;
		act_t last_action;
	} action_rec_t;

	// Predicts the action for every accepted sample and keeps the
	// expectations in order until evt delivers them.
	class action_scoreboard;
		cfg_t        regs;
		cnt_t        level_count;
		bit          has_fired;
		act_t        armed_action;
		act_t        last_fired;
		action_rec_t expected_actions[$];
		int          errors;

		function new();
			regs.press_threshold      = RST_PRESS_THRESHOLD;
			regs.long_press_threshold = RST_LONG_PRESS_THRESHOLD;
			regs.dead_time            = RST_DEAD_TIME;
			level_count  = '0;
			has_fired    = 1'b0;
			armed_action = ACT_NONE;
			last_fired   = ACT_NONE;
			errors       = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, cnt_t data);
			case (idx)
				REG_PRESS_THRESHOLD:      regs.press_threshold      = data;
				REG_LONG_PRESS_THRESHOLD: regs.long_press_threshold = data;
				REG_DEAD_TIME:            regs.dead_time            = data;
				default: ;
			endcase
		endfunction

		function void add_sample(logic pressed);
			bit          fire;
			action_rec_t rec;
			fire       = 1'b0;
			rec.action = ACT_NONE;

			// saturating up/down integration; reaching zero re-enables firing
			if (pressed) begin
				if (level_count != CNT_MAX)
					level_count = level_count + 1'b1;
			end else if (level_count != '0) begin
				level_count = level_count - 1'b1;
				if (level_count == '0)
					has_fired = 1'b0;
			end

			if (has_fired && level_count > regs.dead_time)
				level_count = regs.dead_time;

			if (!has_fired) begin
				// long press wins over short press
				if (regs.long_press_threshold != '0 &&
						level_count >= regs.long_press_threshold) begin
					armed_action = ACT_LONG;
					fire = 1'b1;
				end else if (level_count >= regs.press_threshold) begin
					armed_action = ACT_PRESS;
					fire = (regs.long_press_threshold == '0);
				end
				if (armed_action != ACT_NONE && !pressed)
					fire = 1'b1;
			end

			if (fire) begin
				has_fired    = 1'b1;
				rec.action   = armed_action;
				last_fired   = armed_action;
				armed_action = ACT_NONE;
				level_count  = regs.dead_time;
			end

			rec.last_action = last_fired;
			expected_actions.push_back(rec);
		endfunction

		function void check_result(act_t action, act_t last_action);
			action_rec_t rec;
			if (expected_actions.size() == 0) begin
				$error("unexpected result: action %0d, last_action %0d", action, last_action);
				errors++;
				return;
			end
			rec = expected_actions.pop_front();
			if (action !== rec.action) begin
				$error("action: expected %0d, got %0d", rec.action, action);
				errors++;
			end
			if (last_action !== rec.last_action) begin
				$error("last_action: expected %0d, got %0d", rec.last_action, last_action);
				errors++;
			end
		endfunction

		function int pending();
			return expected_actions.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bdlp_in_if  btn_if ();
	bdlp_out_if evt_if ();
	bdlp_cfg_if cfg_if ();

	button_debounce_long_press_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.btn    (btn_if.sink),
		.evt    (evt_if.source),
		.cfg    (cfg_if.sink)
	);

	action_scoreboard sb = new();

	// percent chance per cycle of an idle sender / stalled receiver
	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int samples_sent   = 0;
	int cycle_count    = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Result side: check every evt transaction, then pick ready for the
	// next cycle. Values read right after the edge are the pre-edge ones.
	initial begin
		evt_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && evt_if.valid && evt_if.ready)
				sb.check_result(evt_if.action, evt_if.last_action);
			evt_if.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// One sample transaction, with random idle cycles ahead of it. valid
	// stays high from one transaction to the next when no idle is drawn.
	task automatic send_sample(logic pressed);
		while ($urandom_range(99) < send_idle_pct) begin
			btn_if.valid <= 1'b0;
			@(posedge clk);
		end
		btn_if.valid   <= 1'b1;
		btn_if.pressed <= pressed;
		do @(posedge clk); while (!btn_if.ready);
		sb.add_sample(pressed);
		samples_sent++;
	endtask

	task automatic send_run(logic pressed, int count);
		for (int i = 0; i < count; i++)
			send_sample(pressed);
	endtask

	// Hold then release, with contact bounce flipping some samples.
	task automatic press_burst(int hold, int rel, int bounce_pct);
		for (int i = 0; i < hold; i++)
			send_sample(!($urandom_range(99) < bounce_pct));
		for (int i = 0; i < rel; i++)
			send_sample($urandom_range(99) < bounce_pct);
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Leaves cfg valid high so back-to-back writes need no second NBA.
	task automatic write_reg(cfg_idx_t idx, cnt_t data);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= data;
		do @(posedge clk); while (!cfg_if.ready);
		sb.write_reg(idx, data);
	endtask

	// Only while idle: every sample has produced its action.
	task automatic apply_config(cnt_t press_thr, cnt_t long_thr, cnt_t dead, bit poke_unused);
		btn_if.valid <= 1'b0;
		wait_drained();
		write_reg(REG_PRESS_THRESHOLD, press_thr);
		write_reg(REG_LONG_PRESS_THRESHOLD, long_thr);
		write_reg(REG_DEAD_TIME, dead);
		if (poke_unused)
			write_reg(REG_UNUSED, cnt_t'($urandom));
		cfg_if.valid <= 1'b0;
	endtask

	function automatic void set_idle_mode(int mode);
		case (mode % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
			default: begin send_idle_pct = 11; recv_stall_pct = 11; end
		endcase
	endfunction

	// Mostly well-formed presses sized around the thresholds; the rest is
	// random chatter.
	task automatic run_random_phase(int n_items);
		int target;
		int reach;
		int hold;
		int rel;
		target = samples_sent + n_items;
		reach  = (sb.regs.long_press_threshold != '0 && sb.regs.long_press_threshold < 100)
			? int'(sb.regs.long_press_threshold)
			: (sb.regs.press_threshold < 100 ? int'(sb.regs.press_threshold) : 30);
		while (samples_sent < target) begin
			if ($urandom_range(99) < 80) begin
				hold = $urandom_range(reach + 6, 0);
				rel  = $urandom_range((sb.regs.dead_time < 40 ? int'(sb.regs.dead_time) : 40) + 4, 0);
				press_burst(hold, rel, $urandom_range(1) ? 0 : 8);
			end else begin
				for (int i = $urandom_range(12, 1); i > 0; i--)
					send_sample(1'($urandom_range(1)));
			end
		end
	endtask

	initial begin
		cnt_t press_thr;
		cnt_t long_thr;
		cnt_t dead;

		arst_n         <= 1'b0;
		btn_if.valid   <= 1'b0;
		btn_if.pressed <= 1'b0;
		cfg_if.valid   <= 1'b0;
		cfg_if.index   <= REG_PRESS_THRESHOLD;
		cfg_if.data    <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// long threshold below press threshold: long press fires, then the
		// counter sits at the top while held and fired
		apply_config(16'd3, 16'd2, CNT_MAX, 1'b1);
		send_run(1'b1, 3);
		send_sample(1'b0);

		// short press fired on release, then a long press
		apply_config(16'd2, 16'd4, 16'd1, 1'b0);
		send_run(1'b0, 2);
		send_run(1'b1, 2);
		send_run(1'b0, 2);
		send_run(1'b1, 4);
		send_sample(1'b0);

		// zero press threshold and zero dead time: fires on the first tick,
		// then stays fired since the counter never leaves zero
		apply_config(16'd0, 16'd0, 16'd0, 1'b0);
		send_sample(1'b0);
		send_sample(1'b1);
		send_run(1'b0, 2);
		send_run(1'b1, 2);

		// long threshold at its top arms a short press, released to fire
		apply_config(16'd2, CNT_MAX, 16'd1, 1'b0);
		send_sample(1'b1);
		send_sample(1'b0);
		send_run(1'b1, 2);
		send_sample(1'b0);

		// press threshold at its top: a long hold never arms
		apply_config(CNT_MAX, 16'd0, 16'd3, 1'b1);
		send_run(1'b0, 6);
		send_run(1'b1, 40);
		send_run(1'b0, 6);

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case ($urandom_range(9))
				0:       press_thr = '0;
				1:       press_thr = CNT_MAX;
				default: press_thr = cnt_t'($urandom_range(30, 1));
			endcase
			case ($urandom_range(9))
				0, 1, 2, 3: long_thr = '0;
				4:          long_thr = CNT_MAX;
				default:    long_thr = cnt_t'($urandom_range(45, 1));
			endcase
			case ($urandom_range(19))
				0, 1:    dead = '0;
				2:       dead = CNT_MAX;
				default: dead = cnt_t'($urandom_range(20, 1));
			endcase
			apply_config(press_thr, long_thr, dead, $urandom_range(3) == 0);
			set_idle_mode(ph);
			run_random_phase(PHASE_ITEMS);
		end

		btn_if.valid <= 1'b0;
		wait_drained();
		repeat (SETTLE_TICKS) @(posedge clk);

		if (sb.errors == 0 && sb.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: button_debounce_long_press_core.f
+incdir+hdl
hdl/bdlp_pkg.sv
hdl/bdlp_ifs.sv
hdl/bdlp_cfg_regs.sv
hdl/bdlp_step.sv
hdl/button_debounce_long_press_core.sv
sim/button_debounce_long_press_core_tb.sv
